### src/rgbhsv_pkg.sv
package rgbhsv_pkg;

  localparam int HueFracBitsDefault  = 7;
  localparam int UnitFracBitsDefault = 16;

  localparam int ChanW = 8;
  localparam int HueW  = 16;
  localparam int UnitW = 17;

  // Queue between front and back.
  localparam int QueueDepth = 4;

  // Hue sector offsets in units of delta (60 degrees each).
  localparam logic [2:0] SectorRed   = 3'd0;
  localparam logic [2:0] SectorGreen = 3'd2;
  localparam logic [2:0] SectorBlue  = 3'd4;

  // Classified pixel handed from front to back.
  typedef struct packed {
    logic [ChanW-1:0] mx;
    logic [ChanW-1:0] delta;
    logic [ChanW+3:0] n;      // sector numerator, already wrapped, 0 to below 6*delta
    logic             gray;
  } rgbhsv_cls_t;

endpackage

### src/rgbhsv_if.sv
interface rgbhsv_in_if;
  logic                     valid;
  logic                     ready;
  logic [rgbhsv_pkg::ChanW-1:0] red;
  logic [rgbhsv_pkg::ChanW-1:0] green;
  logic [rgbhsv_pkg::ChanW-1:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_out_if;
  logic                     valid;
  logic                     ready;
  logic [rgbhsv_pkg::HueW-1:0]  hue;
  logic [rgbhsv_pkg::UnitW-1:0] saturation;
  logic [rgbhsv_pkg::UnitW-1:0] brightness;
  logic                     is_gray;
  modport source (output valid, output hue, output saturation, output brightness,
                  output is_gray, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  input is_gray, output ready);
endinterface

### src/rgb_to_hsv_converter_core.sv
// RGB to HSV converter. Each 8-bit RGB pixel transaction yields one HSV result
// transaction: hue in degrees with HUE_FRAC_BITS fraction bits, saturation
// (delta/max) and brightness (max/255) scaled so 2^UNIT_FRAC_BITS is 1.0, and
// an is_gray flag when all channels are equal. One pixel is accepted every
// clock when the output is taken. The front end registers each pixel into the
// queue, and the back end's bit-serial dividers, one quotient bit per stage,
// set its depth (20 + HUE_FRAC_BITS or 10 + UNIT_FRAC_BITS stages,
// whichever is larger).
module rgb_to_hsv_converter_core #(
  parameter int HUE_FRAC_BITS  = rgbhsv_pkg::HueFracBitsDefault,
  parameter int UNIT_FRAC_BITS = rgbhsv_pkg::UnitFracBitsDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  rgbhsv_in_if.sink  in_ch,
  rgbhsv_out_if.source out_ch
);
  import rgbhsv_pkg::*;

  // Classified pixels move from the front end into a short queue.
  logic        f_valid, f_ready, q_valid, q_ready;
  rgbhsv_cls_t f_cls, q_cls;

  rgbhsv_front u_front (
    .clk, .rst_n, .in_ch,
    .cls_valid(f_valid), .cls_ready(f_ready), .cls(f_cls)
  );

  rgbhsv_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cls),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cls)
  );

  rgbhsv_back #(.HueFracBits(HUE_FRAC_BITS), .UnitFracBits(UNIT_FRAC_BITS)) u_back (
    .clk, .rst_n,
    .cls_valid(q_valid), .cls_ready(q_ready), .cls(q_cls),
    .out_ch
  );
endmodule

### src/rgbhsv_front.sv
module rgbhsv_front (
  input  logic                    clk,
  input  logic                    rst_n,
  rgbhsv_in_if.sink               in_ch,
  output logic                    cls_valid,
  input  logic                    cls_ready,
  output rgbhsv_pkg::rgbhsv_cls_t cls
);
  import rgbhsv_pkg::*;

  logic        valid_r;
  rgbhsv_cls_t cls_r, cls_nxt;
  logic [ChanW-1:0] r, g, b, mx, mn, dl;
  logic [ChanW+3:0] n_raw;

  assign r = in_ch.red;
  assign g = in_ch.green;
  assign b = in_ch.blue;

  always_comb begin
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    // Signed arithmetic in 12 bits; result is kept in range by the wrap.
    priority if (r == mx) begin
      n_raw = {4'd0, g} - {4'd0, b};
    end else if (g == mx) begin
      n_raw = {3'd0, dl, 1'b0} + {4'd0, b} - {4'd0, r};
    end else begin
      n_raw = {2'd0, dl, 2'b0} + {4'd0, r} - {4'd0, g};
    end
    if (n_raw[ChanW+3]) n_raw = n_raw + {1'b0, dl, 2'b0} + {2'b0, dl, 1'b0};
    cls_nxt.mx    = mx;
    cls_nxt.delta = dl;
    cls_nxt.n     = n_raw;
    cls_nxt.gray  = (dl == '0);
  end

  assign in_ch.ready = !valid_r || cls_ready;
  assign cls_valid   = valid_r;
  assign cls         = cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      cls_r <= cls_nxt;
    end
  end

  a_gray_delta: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (cls_r.gray == (cls_r.delta == '0)))
    else $error("gray flag disagrees with delta");
  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !cls_r.gray |-> (cls_r.n < 12'(cls_r.delta) * 12'd6))
    else $error("hue numerator out of range");
  a_delta_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (cls_r.delta <= cls_r.mx))
    else $error("delta above max");
endmodule

### src/rgbhsv_queue.sv
module rgbhsv_queue #(
  parameter int Depth = rgbhsv_pkg::QueueDepth
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_valid,
  output logic                    wr_ready,
  input  rgbhsv_pkg::rgbhsv_cls_t wr_data,
  output logic                    rd_valid,
  input  logic                    rd_ready,
  output rgbhsv_pkg::rgbhsv_cls_t rd_data
);
  import rgbhsv_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  rgbhsv_cls_t     mem_r [Depth];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  logic            push, pop;

  assign wr_ready = (cnt_r != (AW+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem_r[wp_r] <= wr_data;
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(Depth)) else $error("queue count overflow");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (AW+1)'(Depth)) && !pop |=> (cnt_r == (AW+1)'(Depth)))
    else $error("queue full count changed without a pop");
  a_empty_stay: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) && !wr_valid |=> (cnt_r == '0))
    else $error("empty queue gained an entry");
endmodule

### src/rgbhsv_back.sv
// Back end: two pipelined long divisions with round to nearest, for hue and
// saturation. Quotients are computed by restoring division, one bit per stage.
// Brightness divides by a constant, so it comes from a table indexed by max
// and simply rides along the pipeline.
module rgbhsv_back #(
  parameter int HueFracBits  = rgbhsv_pkg::HueFracBitsDefault,
  parameter int UnitFracBits = rgbhsv_pkg::UnitFracBitsDefault
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cls_valid,
  output logic                    cls_ready,
  input  rgbhsv_pkg::rgbhsv_cls_t cls,
  rgbhsv_out_if.source            out_ch
);
  import rgbhsv_pkg::*;

  // Numerators doubled with den added: q = (2*num + den) / (2*den).
  localparam int HueNumW = 12 + 6 + HueFracBits + 2;     // 60*2^H*n, n < 2^11
  localparam int UnitNumW = ChanW + UnitFracBits + 2;
  localparam int NumW = (HueNumW > UnitNumW) ? HueNumW : UnitNumW;
  localparam int DenW = ChanW + 2;
  localparam int Steps = NumW;
  localparam int FullHue = 360 * (2 ** HueFracBits);

  typedef logic [255:0][UnitW-1:0] val_tab_t;

  // Rounded max * 2^UnitFracBits / 255 for every possible max.
  function automatic val_tab_t make_val_tab();
    val_tab_t t;
    for (int m = 0; m < 256; m++) begin
      t[m] = UnitW'(((longint'(m) << (UnitFracBits + 1)) + 255) / 510);
    end
    return t;
  endfunction

  localparam val_tab_t ValTab = make_val_tab();

  typedef struct packed {
    logic [NumW-1:0] q;     // shifting numerator becomes quotient
    logic [DenW:0]   rem;
    logic [DenW-1:0] den;
  } div_t;

  typedef struct packed {
    div_t             hue;
    div_t             sat;
    logic [UnitW-1:0] val;
    logic             gray;
  } stage_t;

  stage_t          st_r [Steps+1];
  logic [Steps:0]  v_r;
  logic            adv;
  stage_t          st0;
  logic [NumW-1:0] hue_num, sat_num;

  // Output register holds the last stage; pipeline moves when it is free.
  assign adv       = !out_ch.valid || out_ch.ready;
  assign cls_ready = adv;

  always_comb begin
    hue_num = NumW'(({(NumW-12)'(0), cls.n} * NumW'(60)) << (HueFracBits + 1))
              + NumW'(cls.delta);
    sat_num = (NumW'(cls.delta) << (UnitFracBits + 1)) + NumW'(cls.mx);
    st0.hue = '{q: hue_num, rem: '0, den: DenW'({cls.delta, 1'b0})};
    st0.sat = '{q: sat_num, rem: '0, den: DenW'({cls.mx, 1'b0})};
    st0.val = ValTab[cls.mx];
    st0.gray = cls.gray;
  end

  function automatic div_t div_step(div_t d);
    logic [DenW+1:0] t;
    div_t o;
    t = {d.rem, d.q[NumW-1]};
    o = d;
    if (t >= {2'b0, d.den}) begin
      o.rem = (DenW+1)'(t - {2'b0, d.den});
      o.q   = {d.q[NumW-2:0], 1'b1};
    end else begin
      o.rem = (DenW+1)'(t);
      o.q   = {d.q[NumW-2:0], 1'b0};
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[Steps-1:0], cls_valid};
    end
    if (adv) begin
      st_r[0] <= st0;
      for (int i = 1; i <= Steps; i++) begin
        st_r[i].hue  <= div_step(st_r[i-1].hue);
        st_r[i].sat  <= div_step(st_r[i-1].sat);
        st_r[i].val  <= st_r[i-1].val;
        st_r[i].gray <= st_r[i-1].gray;
      end
    end
  end

  logic [NumW-1:0] hq;
  assign hq = st_r[Steps].hue.q;
  assign out_ch.valid      = v_r[Steps];
  assign out_ch.is_gray    = st_r[Steps].gray;
  assign out_ch.brightness = st_r[Steps].val;
  assign out_ch.saturation = st_r[Steps].gray ? '0 : UnitW'(st_r[Steps].sat.q);
  assign out_ch.hue = (st_r[Steps].gray || hq >= NumW'(FullHue)) ? '0 : HueW'(hq);

  a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_gray |-> (out_ch.hue == '0 && out_ch.saturation == '0))
    else $error("gray result not zeroed");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> cls_ready) else $error("back end stalled while empty");
endmodule
